// ===== hw/rtl/kvts_pkg.sv =====
// shared types and constants of the key-value table store
// no dependencies

package kvts_pkg;

  localparam int unsigned DefaultCapacity = 64;
  localparam int unsigned KeyW = 32;
  localparam int unsigned ValW = 32;

  typedef struct packed {
    logic start;
    logic scan;
    logic update;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic done;
  } status_t;

endpackage

// ===== hw/rtl/kvts_ctrl.sv =====
// controller state machine of the key-value table store
// depends on kvts_pkg

module kvts_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  kvts_pkg::status_t status_i,
  output kvts_pkg::cmd_t    cmd_o
);
  import kvts_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StUpdate,
    StReport
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   can_load;

  assign can_load = !out_vld_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    out_vld_d = out_vld_q;
    cmd_o     = '0;
    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StScan;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (status_i.hit || status_i.done) begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        state_d      = StReport;
      end
      StReport: begin
        if (can_load) begin
          cmd_o.load = 1'b1;
          out_vld_d  = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_vld_q;

endmodule

// ===== hw/rtl/kvts_dpath.sv =====
// datapath of the key-value table store: key and value memories,
// fill count, scan counter, compare and result registers; depends on kvts_pkg

module kvts_dpath #(
  parameter int unsigned CAPACITY = kvts_pkg::DefaultCapacity
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  kvts_pkg::cmd_t                   cmd_i,
  output kvts_pkg::status_t                status_o,
  input  logic                             mode_i,
  input  logic signed [kvts_pkg::KeyW-1:0] key_i,
  input  logic signed [kvts_pkg::ValW-1:0] value_i,
  output logic                             found_o,
  output logic signed [kvts_pkg::ValW-1:0] read_value_o,
  output logic                             table_full_o
);
  import kvts_pkg::*;

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  logic [KeyW-1:0] key_mem [CAPACITY];
  logic [ValW-1:0] val_mem [CAPACITY];

  logic            mode_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] val_q;
  logic [CntW-1:0] idx_q;
  logic [CntW-1:0] fill_q;
  logic            rd_vld_q;
  logic [IdxW-1:0] rd_idx_q;
  logic [KeyW-1:0] key_rd_q;
  logic [ValW-1:0] val_rd_q;
  logic            found_q;
  logic [IdxW-1:0] slot_q;
  logic            full_q;
  logic            res_found_q;
  logic [ValW-1:0] res_val_q;
  logic            res_full_q;

  logic            hit;
  logic            more;
  logic            issue;
  logic            is_full;
  logic            append;
  logic            val_we;
  logic [IdxW-1:0] waddr;

  assign hit     = cmd_i.scan && rd_vld_q && (key_rd_q == key_q);
  assign more    = (idx_q < fill_q);
  assign issue   = cmd_i.scan && !hit && more;
  assign is_full = (fill_q == CapCnt);
  assign append  = cmd_i.update && mode_q && !found_q && !is_full;
  assign val_we  = cmd_i.update && mode_q && (found_q || !is_full);
  assign waddr   = found_q ? slot_q : fill_q[IdxW-1:0];

  assign status_o.hit  = hit;
  assign status_o.done = !rd_vld_q && !more;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mode_q <= mode_i;
      key_q  <= key_i;
      val_q  <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      fill_q   <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        idx_q    <= '0;
        rd_vld_q <= 1'b0;
        found_q  <= 1'b0;
      end else if (cmd_i.scan) begin
        rd_vld_q <= issue;
        if (issue) begin
          idx_q <= idx_q + 1'b1;
        end
        if (hit) begin
          found_q <= 1'b1;
        end
      end
      if (append) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_idx_q <= idx_q[IdxW-1:0];
    end
    if (hit) begin
      slot_q <= rd_idx_q;
    end
    if (cmd_i.update) begin
      full_q <= mode_q && !found_q && is_full;
    end
  end

  // key memory
  always_ff @(posedge clk_i) begin
    if (issue) begin
      key_rd_q <= key_mem[idx_q[IdxW-1:0]];
    end
    if (append) begin
      key_mem[fill_q[IdxW-1:0]] <= key_q;
    end
  end

  // value memory
  always_ff @(posedge clk_i) begin
    if (issue) begin
      val_rd_q <= val_mem[idx_q[IdxW-1:0]];
    end
    if (val_we) begin
      val_mem[waddr] <= val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_found_q <= found_q;
      res_val_q   <= (!mode_q && found_q) ? val_rd_q : '0;
      res_full_q  <= full_q;
    end
  end

  assign found_o      = res_found_q;
  assign read_value_o = res_val_q;
  assign table_full_o = res_full_q;

endmodule

// ===== hw/rtl/key_value_table_store.sv =====
// top level of the key-value table store: controller plus datapath
// depends on kvts_pkg, kvts_ctrl and kvts_dpath
//
// usage:
//   input channel (in_valid_i / in_stall_o) carries one request: mode_i
//   selects lookup (0) or add (1), with key_i and value_i
//   output channel (out_valid_o / out_stall_i) returns one result per
//   request: found_o, read_value_o (lookup hit only) and table_full_o
//   a request scans the stored keys in insertion order, one per cycle
//   through the registered read port of the key memory, stopping at the
//   first match; at most the fill count of entries (up to CAPACITY) is
//   scanned, then the controller steps through an update state and a
//   report state, which moves the result into the output register
//   one request is worked on at a time; the next is taken the cycle after
//   the result moves into the output register, even while the receiver
//   stalls it
//   a stalled result holds; a new result waits in the controller until
//   the output register frees up
//   reset empties the table at once (fill count zero); memory contents
//   are left as they are and never read before written

module key_value_table_store #(
  parameter int unsigned CAPACITY = kvts_pkg::DefaultCapacity
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             mode_i,
  input  logic signed [kvts_pkg::KeyW-1:0] key_i,
  input  logic signed [kvts_pkg::ValW-1:0] value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             found_o,
  output logic signed [kvts_pkg::ValW-1:0] read_value_o,
  output logic                             table_full_o
);
  import kvts_pkg::*;

  cmd_t    cmd;
  status_t status;

  kvts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  kvts_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .mode_i       (mode_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .found_o      (found_o),
    .read_value_o (read_value_o),
    .table_full_o (table_full_o)
  );

endmodule
